>>> rtl/lrs_pkg.sv
// shared constants, types and microcode table of the lagrange resampler
package lrs_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 20;
  localparam int RATE_W       = 24;
  localparam int RING_DEPTH   = 5;
  localparam int SLOT_W       = $clog2(RING_DEPTH);
  localparam int MAX_RUN      = 16;
  localparam int RUN_W        = $clog2(MAX_RUN);

  // the rate register must hold the 1/16 floor too
  localparam int RATE_REG_W = (RATE_W > FRAC_BITS - 3) ? RATE_W : FRAC_BITS - 3;
  // phase stays below 1.0 plus the largest rate
  localparam int PHASE_W = ((RATE_REG_W > FRAC_BITS + 1) ? RATE_REG_W : FRAC_BITS + 1) + 1;

  // node distance magnitude below 3.0, weight magnitude below 16.0
  localparam int DM_W  = FRAC_BITS + 2;
  localparam int MA_W  = FRAC_BITS + 4;
  localparam int MB_W  = (MA_W > SAMPLE_WIDTH) ? MA_W : SAMPLE_WIDTH;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = SAMPLE_WIDTH + FRAC_BITS + 5;

  // divide by 3 as multiply by reciprocal, exact for operands below 2^MA_W
  localparam int          DIV3_K   = FRAC_BITS + 5;
  localparam logic [63:0] DIV3_M64 = ((64'd1 << DIV3_K) + 64'd2) / 64'd3;

  localparam int UPC_W     = 6;
  localparam int UCODE_LEN = 61;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,   // weight <= node distance
    OP_MULD,   // product <= weight * node distance
    OP_RND,    // weight <= product rounded to frac bits
    OP_PRE,    // weight <= (weight + d/2) >> shift, denominator prescale
    OP_MUL3,   // product <= weight * reciprocal of 3
    OP_WB3,    // weight <= product >> reciprocal shift
    OP_MULS,   // product <= weight * sample
    OP_ACC,    // acc <= acc +/- product
    OP_ABS,    // acc <= |acc|, keep sign
    OP_RACC,   // acc <= rounded to integer
    OP_EMIT    // load output register, advance phase
  } uop_t;

  typedef enum logic [1:0] {
    DV_4,
    DV_6,
    DV_24
  } dsel_t;

  typedef enum logic {
    BR_NEXT,
    BR_EMIT
  } br_t;

  typedef struct packed {
    uop_t             op;
    logic [2:0]       node;
    logic [2:0]       term;
    dsel_t            dsel;
    logic             flip;
    logic             clr;
    br_t              br;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // sequencer to datapath
  typedef struct packed {
    uop_t       op;
    logic [2:0] node;
    logic [2:0] term;
    dsel_t      dsel;
    logic       flip;
    logic       clr;
    logic       take;
  } lrs_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic start_ok;
    logic emit_stall;
    logic more;
  } lrs_stat_t;

  function automatic ucw_t uw(uop_t op, logic [2:0] node, logic [2:0] term, dsel_t dsel,
                              logic flip, logic clr);
    ucw_t w;
    w.op     = op;
    w.node   = node;
    w.term   = term;
    w.dsel   = dsel;
    w.flip   = flip;
    w.clr    = clr;
    w.br     = BR_NEXT;
    w.target = '0;
    return w;
  endfunction

  // one output: five weights, each a product chain over the other nodes,
  // a denominator step and a multiply-accumulate, then round and emit
  function automatic ucw_t urom(logic [UPC_W-1:0] a);
    ucw_t w;
    unique case (a)
      // weight 0, nodes 1..4, denominator 24
      6'd0:  w = uw(OP_LOAD, 3'd1, 3'd0, DV_4, 1'b0, 1'b1);
      6'd1:  w = uw(OP_MULD, 3'd2, 3'd0, DV_4, 1'b0, 1'b0);
      6'd2:  w = uw(OP_RND,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd3:  w = uw(OP_MULD, 3'd3, 3'd0, DV_4, 1'b0, 1'b0);
      6'd4:  w = uw(OP_RND,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd5:  w = uw(OP_MULD, 3'd4, 3'd0, DV_4, 1'b0, 1'b0);
      6'd6:  w = uw(OP_RND,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd7:  w = uw(OP_PRE,  3'd0, 3'd0, DV_24, 1'b0, 1'b0);
      6'd8:  w = uw(OP_MUL3, 3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd9:  w = uw(OP_WB3,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd10: w = uw(OP_MULS, 3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd11: w = uw(OP_ACC,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      // weight 1, nodes 0,2,3,4, denominator -6
      6'd12: w = uw(OP_LOAD, 3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd13: w = uw(OP_MULD, 3'd2, 3'd1, DV_4, 1'b0, 1'b0);
      6'd14: w = uw(OP_RND,  3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd15: w = uw(OP_MULD, 3'd3, 3'd1, DV_4, 1'b0, 1'b0);
      6'd16: w = uw(OP_RND,  3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd17: w = uw(OP_MULD, 3'd4, 3'd1, DV_4, 1'b0, 1'b0);
      6'd18: w = uw(OP_RND,  3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd19: w = uw(OP_PRE,  3'd0, 3'd1, DV_6, 1'b1, 1'b0);
      6'd20: w = uw(OP_MUL3, 3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd21: w = uw(OP_WB3,  3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd22: w = uw(OP_MULS, 3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      6'd23: w = uw(OP_ACC,  3'd0, 3'd1, DV_4, 1'b0, 1'b0);
      // weight 2, nodes 0,1,3,4, denominator 4
      6'd24: w = uw(OP_LOAD, 3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd25: w = uw(OP_MULD, 3'd1, 3'd2, DV_4, 1'b0, 1'b0);
      6'd26: w = uw(OP_RND,  3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd27: w = uw(OP_MULD, 3'd3, 3'd2, DV_4, 1'b0, 1'b0);
      6'd28: w = uw(OP_RND,  3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd29: w = uw(OP_MULD, 3'd4, 3'd2, DV_4, 1'b0, 1'b0);
      6'd30: w = uw(OP_RND,  3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd31: w = uw(OP_PRE,  3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd32: w = uw(OP_MULS, 3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      6'd33: w = uw(OP_ACC,  3'd0, 3'd2, DV_4, 1'b0, 1'b0);
      // weight 3, nodes 0,1,2,4, denominator -6
      6'd34: w = uw(OP_LOAD, 3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd35: w = uw(OP_MULD, 3'd1, 3'd3, DV_4, 1'b0, 1'b0);
      6'd36: w = uw(OP_RND,  3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd37: w = uw(OP_MULD, 3'd2, 3'd3, DV_4, 1'b0, 1'b0);
      6'd38: w = uw(OP_RND,  3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd39: w = uw(OP_MULD, 3'd4, 3'd3, DV_4, 1'b0, 1'b0);
      6'd40: w = uw(OP_RND,  3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd41: w = uw(OP_PRE,  3'd0, 3'd3, DV_6, 1'b1, 1'b0);
      6'd42: w = uw(OP_MUL3, 3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd43: w = uw(OP_WB3,  3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd44: w = uw(OP_MULS, 3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      6'd45: w = uw(OP_ACC,  3'd0, 3'd3, DV_4, 1'b0, 1'b0);
      // weight 4, nodes 0..3, denominator 24
      6'd46: w = uw(OP_LOAD, 3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd47: w = uw(OP_MULD, 3'd1, 3'd4, DV_4, 1'b0, 1'b0);
      6'd48: w = uw(OP_RND,  3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd49: w = uw(OP_MULD, 3'd2, 3'd4, DV_4, 1'b0, 1'b0);
      6'd50: w = uw(OP_RND,  3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd51: w = uw(OP_MULD, 3'd3, 3'd4, DV_4, 1'b0, 1'b0);
      6'd52: w = uw(OP_RND,  3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd53: w = uw(OP_PRE,  3'd0, 3'd4, DV_24, 1'b0, 1'b0);
      6'd54: w = uw(OP_MUL3, 3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd55: w = uw(OP_WB3,  3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd56: w = uw(OP_MULS, 3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      6'd57: w = uw(OP_ACC,  3'd0, 3'd4, DV_4, 1'b0, 1'b0);
      // finish
      6'd58: w = uw(OP_ABS,  3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd59: w = uw(OP_RACC, 3'd0, 3'd0, DV_4, 1'b0, 1'b0);
      6'd60: begin
        w        = uw(OP_EMIT, 3'd0, 3'd0, DV_4, 1'b0, 1'b0);
        w.br     = BR_EMIT;
        w.target = '0;
      end
      default: w = uw(OP_NOP, 3'd0, 3'd0, DV_4, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/lrs_useq.sv
// microcode sequencer: step counter, control store and emit branch
module lrs_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrs_pkg::lrs_stat_t stat,
  output lrs_pkg::lrs_ctl_t  ctl
);
  import lrs_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucw_t             cw;

  assign cw       = urom(upc_r);
  assign in_ready = !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    ctl.op   = OP_NOP;
    ctl.node = cw.node;
    ctl.term = cw.term;
    ctl.dsel = cw.dsel;
    ctl.flip = cw.flip;
    ctl.clr  = cw.clr;
    ctl.take = 1'b0;
    if (!busy_r) begin
      ctl.take = in_valid;
      if (in_valid) begin
        busy_nxt = stat.start_ok;
        upc_nxt  = '0;
      end
    end else begin
      unique case (cw.br)
        BR_EMIT: begin
          // hold while the output register is still full
          if (!stat.emit_stall) begin
            ctl.op = cw.op;
            if (stat.more) begin
              upc_nxt = cw.target;
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
        BR_NEXT: begin
          ctl.op  = cw.op;
          upc_nxt = upc_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

>>> rtl/lrs_dpath.sv
// datapath: sample ring, phase, one shared multiplier, weight and accumulator
module lrs_dpath (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lrs_pkg::lrs_ctl_t                        ctl,
  output lrs_pkg::lrs_stat_t                       stat,
  input  logic signed [lrs_pkg::SAMPLE_WIDTH-1:0]  in_sample,
  input  logic                                     cfg_we,
  input  logic [lrs_pkg::RATE_W-1:0]               cfg_wdata,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [lrs_pkg::SAMPLE_WIDTH-1:0]  out_sample,
  output logic                                     out_last_in_run
);
  import lrs_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  localparam logic [PHASE_W-1:0]    ONE_Q    = PHASE_W'(1) << FRAC_BITS;
  localparam logic [RATE_REG_W-1:0] RATE_ONE = RATE_REG_W'(1) << FRAC_BITS;
  localparam logic [RATE_REG_W-1:0] RATE_MIN = RATE_REG_W'(1) << (FRAC_BITS - 4);
  localparam logic [DM_W-1:0]       DM_ONE   = DM_W'(1) << FRAC_BITS;
  localparam logic [DM_W-1:0]       DM_TWO   = DM_W'(2) << FRAC_BITS;
  localparam logic [P_W-1:0]        HALF_P   = P_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] LIM_A  = ACC_W'(1) << (SW - 1);
  localparam logic [MB_W-1:0]       DIV3_M   = MB_W'(DIV3_M64);
  localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
  localparam logic [SW-1:0]         SAT_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]         SAT_MIN  = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0]   ring_r [RING_DEPTH];
  logic [SLOT_W-1:0]      slot_r;
  logic [PHASE_W-1:0]     phase_r;
  logic [RATE_REG_W-1:0]  rate_r;
  logic [RUN_W-1:0]       run_r;
  logic                   out_valid_r;
  logic [SW-1:0]          out_sample_r;
  logic                   out_last_r;

  logic [MA_W-1:0]        w_mag_r;
  logic                   w_neg_r;
  logic [P_W-1:0]         p_r;
  logic                   p_neg_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                   acc_neg_r;

  logic [PHASE_W-1:0]     phase_sub, phase_add;
  logic                   more;
  logic [FRAC_BITS-1:0]   x;
  logic [DM_W-1:0]        dmag;
  logic                   dneg;
  logic [SLOT_W:0]        ridx_sum;
  logic [SLOT_W-1:0]      ridx;
  logic [SW-1:0]          smp;
  logic                   sneg;
  logic [SW-1:0]          smag;
  logic [MB_W-1:0]        mb;
  logic [P_W-1:0]         prod;
  logic [MA_W:0]          pre_sum;
  logic [MA_W-1:0]        pre_w;
  logic [P_W-1:0]         rnd_sum;
  logic [MA_W-1:0]        rnd_w;
  logic [MA_W-1:0]        wb3_w;
  logic signed [ACC_W-1:0] pm;
  logic signed [ACC_W-1:0] acc_abs;
  logic signed [ACC_W-1:0] acc_rnd;
  logic [SW-1:0]          sat_val;
  logic [RATE_REG_W-1:0]  rate_wr;

  // phase bookkeeping
  assign phase_sub = phase_r - ONE_Q;
  assign phase_add = phase_r + PHASE_W'(rate_r);
  assign more      = (phase_add < ONE_Q) && (run_r != RUN_W'(MAX_RUN - 1));

  assign stat.start_ok   = phase_sub < ONE_Q;
  assign stat.emit_stall = out_valid_r && !out_ready;
  assign stat.more       = more;

  // node distance (node - 2) - x as sign and magnitude
  assign x    = phase_r[FRAC_BITS-1:0];
  assign dneg = ctl.node <= 3'd2;

  always_comb begin
    unique case (ctl.node)
      3'd0:    dmag = DM_TWO + DM_W'(x);
      3'd1:    dmag = DM_ONE + DM_W'(x);
      3'd2:    dmag = DM_W'(x);
      3'd3:    dmag = DM_ONE - DM_W'(x);
      3'd4:    dmag = DM_TWO - DM_W'(x);
      default: dmag = '0;
    endcase
  end

  // ring read, oldest sample first
  assign ridx_sum = {1'b0, slot_r} + (SLOT_W+1)'(ctl.term);
  assign ridx     = (ridx_sum >= (SLOT_W+1)'(RING_DEPTH)) ?
                    SLOT_W'(ridx_sum - (SLOT_W+1)'(RING_DEPTH)) : SLOT_W'(ridx_sum);
  assign smp      = ring_r[ridx];
  assign sneg     = smp[SW-1];
  assign smag     = sneg ? (~smp + 1'b1) : smp;

  // shared multiplier, magnitudes only
  always_comb begin
    unique case (ctl.op)
      OP_MUL3: mb = DIV3_M;
      OP_MULS: mb = MB_W'(smag);
      default: mb = MB_W'(dmag);
    endcase
  end
  assign prod = P_W'(w_mag_r) * P_W'(mb);

  // denominator prescale, rounding half away from zero on magnitudes
  always_comb begin
    unique case (ctl.dsel)
      DV_4: begin
        pre_sum = {1'b0, w_mag_r} + (MA_W+1)'(2);
        pre_w   = MA_W'(pre_sum >> 2);
      end
      DV_6: begin
        pre_sum = {1'b0, w_mag_r} + (MA_W+1)'(3);
        pre_w   = MA_W'(pre_sum >> 1);
      end
      DV_24: begin
        pre_sum = {1'b0, w_mag_r} + (MA_W+1)'(12);
        pre_w   = MA_W'(pre_sum >> 3);
      end
      default: begin
        pre_sum = {1'b0, w_mag_r};
        pre_w   = w_mag_r;
      end
    endcase
  end

  assign rnd_sum = p_r + HALF_P;
  assign rnd_w   = MA_W'(rnd_sum >> FRAC_BITS);
  assign wb3_w   = MA_W'(p_r >> DIV3_K);
  assign pm      = signed'(ACC_W'(p_r));
  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign acc_rnd = (acc_r + HALF_A) >>> FRAC_BITS;

  // saturate the rounded magnitude back to a signed sample
  always_comb begin
    priority if (!acc_neg_r && (acc_r > LIM_A - 1)) begin
      sat_val = SAT_MAX;
    end else if (acc_neg_r && (acc_r > LIM_A)) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = acc_neg_r ? -acc_r[SW-1:0] : acc_r[SW-1:0];
    end
  end

  assign rate_wr = (RATE_REG_W'(cfg_wdata) < RATE_MIN) ? RATE_MIN : RATE_REG_W'(cfg_wdata);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      slot_r      <= '0;
      phase_r     <= ONE_Q;
      rate_r      <= RATE_ONE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= rate_wr;
      end
      if (ctl.take) begin
        ring_r[slot_r] <= in_sample;
        slot_r         <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        phase_r        <= phase_sub;
        run_r          <= '0;
      end
      if (ctl.op == OP_EMIT) begin
        phase_r     <= phase_add;
        run_r       <= run_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        w_mag_r <= MA_W'(dmag);
        w_neg_r <= dneg;
        if (ctl.clr) begin
          acc_r <= '0;
        end
      end
      OP_MULD: begin
        p_r     <= prod;
        p_neg_r <= w_neg_r ^ dneg;
      end
      OP_RND: begin
        w_mag_r <= rnd_w;
        w_neg_r <= p_neg_r;
      end
      OP_PRE: begin
        w_mag_r <= pre_w;
        w_neg_r <= w_neg_r ^ ctl.flip;
      end
      OP_MUL3: begin
        p_r     <= prod;
        p_neg_r <= w_neg_r;
      end
      OP_WB3: begin
        w_mag_r <= wb3_w;
        w_neg_r <= p_neg_r;
      end
      OP_MULS: begin
        p_r     <= prod;
        p_neg_r <= w_neg_r ^ sneg;
      end
      OP_ACC: begin
        acc_r <= p_neg_r ? acc_r - pm : acc_r + pm;
      end
      OP_ABS: begin
        acc_r     <= acc_abs;
        acc_neg_r <= acc_r[ACC_W-1];
      end
      OP_RACC: begin
        acc_r <= acc_rnd;
      end
      OP_EMIT: begin
        out_sample_r <= sat_val;
        out_last_r   <= !more;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = signed'(out_sample_r);
  assign out_last_in_run = out_last_r;

endmodule

>>> rtl/lagrange_resampler_core.sv
// top level of the 5-point lagrange interpolation resampler
//
// sample-rate converter: each accepted input item is written over the oldest
// of five stored samples and the read phase drops by 1.0; while the phase is
// below 1.0 the block produces one output item, the lagrange polynomial
// through the five samples (oldest at node -2) evaluated at the phase, and
// then adds cfg rate_ratio (source over target rate, unsigned, 20 fraction
// bits, floored at 1/16) to the phase. arithmetic is fixed point with 20
// fraction bits, every rounding half away from zero but the divide by 3,
// which truncates, and the result saturated to 16 bits. out_last_in_run
// marks the last output caused by an input; an input may cause no output
// at all and at most 16. a microcoded sequencer steps one shared multiplier
// through a 61-step program per output (four node products and a denominator
// step per weight, a multiply-accumulate per weight, round and emit), and
// the emit step stalls while the previous result is still in the output
// register, unread. in_ready is high only between runs; a finished output
// sits in the output register while the next one is being computed. write
// cfg_wdata only while no run is active. reset clears the stored samples to
// zero, sets the phase and the rate to 1.0.
module lagrange_resampler_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lrs_pkg::SAMPLE_WIDTH-1:0] in_sample,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lrs_pkg::SAMPLE_WIDTH-1:0] out_sample,
  output logic                                    out_last_in_run,
  // rate register write
  input  logic                                    cfg_we,
  input  logic [lrs_pkg::RATE_W-1:0]              cfg_wdata
);
  import lrs_pkg::*;

  lrs_ctl_t  ctl;
  lrs_stat_t stat;

  // step counter and control store
  lrs_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // sample ring, phase, multiplier, accumulator, output register
  lrs_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_sample       (in_sample),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last_in_run (out_last_in_run)
  );

endmodule
